// ===== rtl/core/uart_bootloader_command_parser_macros.svh =====
`ifndef UART_BOOTLOADER_COMMAND_PARSER_MACROS_SVH
`define UART_BOOTLOADER_COMMAND_PARSER_MACROS_SVH

// Implication checked in the same cycle, switched off while reset is held.
`define UBCP_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, switched off while reset is held.
`define UBCP_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ubcp_pkg.sv =====
package ubcp_pkg;

  localparam int MAX_WRITE_BYTES_DEF = 31;

  // Frame lengths never exceed 256 bytes, so nine bits cover every length.
  localparam int LEN_W = 9;

  // Fixed results that one word can cause, not counting program requests.
  localparam int TAIL_DEPTH = 3;

  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_BYTE    = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  localparam logic [7:0] CODE_ACK     = 8'h06;
  localparam logic [7:0] CMD_ERASE    = 8'h43;
  localparam logic [7:0] CMD_WRITE    = 8'h31;
  localparam logic [7:0] CMD_CHECK    = 8'h51;
  localparam logic [7:0] CMD_JUMP     = 8'hA1;
  localparam logic [7:0] GLOBAL_ERASE = 8'hFF;

  typedef enum logic [2:0] {
    ACT_ACK   = 3'd0,
    ACT_NACK  = 3'd1,
    ACT_ERASE = 3'd2,
    ACT_PROG  = 3'd3,
    ACT_CHECK = 3'd4,
    ACT_JUMP  = 3'd5
  } action_t;

  typedef enum logic [8:0] {
    PH_HANDSHAKE = 9'b000000001,
    PH_COMMAND   = 9'b000000010,
    PH_ERASE     = 9'b000000100,
    PH_WADDR     = 9'b000001000,
    PH_WCOUNT    = 9'b000010000,
    PH_WDATA     = 9'b000100000,
    PH_CSTART    = 9'b001000000,
    PH_CEND      = 9'b010000000,
    PH_HALTED    = 9'b100000000
  } phase_t;

endpackage

// ===== rtl/core/ubcp_ram.sv =====
module ubcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/uart_bootloader_command_parser.sv =====
// Bootloader command parser.
// Input channel: one word per UART event. in_tuser gives the event kind
// (start, byte received, receive timeout) and in_tdata the received byte.
// Output channel: one word per request or answer: ACK, NACK, sector erase,
// program byte, check range or jump. out_tlast marks the final word caused
// by one input word.
// The results of an input word pass through the result sequencer into the
// output register, one per cycle while out_tready is high.
// The input is held off until the last result of the previous word has
// been moved into the output register. A valid write-data frame replays
// up to MAX_WRITE_BYTES buffered bytes, paced by one read per cycle of
// the data buffer RAM while the output is not stalled.
// Reset puts the parser in front of the handshake frame with nothing
// pending. While the receiver stalls, the current result holds and the
// parser stops producing; input words are accepted again once all pending
// results are in the output register.
module uart_bootloader_command_parser #(
  parameter int MAX_WRITE_BYTES = ubcp_pkg::MAX_WRITE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] address, [63:32] end_address, [71:64] data_byte,
  // [79:72] first_sector, [87:80] sector_count
  output logic [87:0] out_tdata,
  output logic [2:0]  out_tuser,  // [2:0] action
  output logic        out_tlast
);

`include "uart_bootloader_command_parser_macros.svh"

  localparam int DEPTH = MAX_WRITE_BYTES + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int BI_W  = ($clog2(MAX_WRITE_BYTES + 2) > 3) ? $clog2(MAX_WRITE_BYTES + 2) : 3;
  localparam int LW    = ubcp_pkg::LEN_W;

  // Parser state.
  ubcp_pkg::phase_t phase_r, phase_nxt;
  logic [BI_W-1:0]  bi_r, bi_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [31:0]      accum_r, accum_nxt;
  logic [31:0]      range_start_r, range_start_nxt;
  logic [7:0]       wc_r, wc_nxt;
  logic [7:0]       e0_r, e0_nxt;
  logic [7:0]       e1_r, e1_nxt;

  // Result sequencer.
  logic [AW-1:0]     prog_left_r, prog_left_nxt;
  logic [AW-1:0]     prog_idx_r, prog_idx_nxt;
  logic [1:0]        tail_cnt_r, tail_cnt_nxt;
  ubcp_pkg::action_t tail_act_r [ubcp_pkg::TAIL_DEPTH];
  ubcp_pkg::action_t tail_act_nxt [ubcp_pkg::TAIL_DEPTH];

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  ubcp_pkg::action_t out_act_r, out_act_nxt;
  logic [31:0]       out_addr_r, out_addr_nxt;
  logic [31:0]       out_end_r, out_end_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic [7:0]        out_first_r, out_first_nxt;
  logic [7:0]        out_count_r, out_count_nxt;
  logic              out_last_r, out_last_nxt;

  logic            in_acc;
  logic            busy;
  logic            emit;
  logic [7:0]      b;
  logic [7:0]      xor_new;
  logic [BI_W-1:0] k_inc;
  logic [LW-1:0]   frame_len;
  logic            done;
  logic            ram_we;
  logic [7:0]      ram_rdata;

  assign busy      = (prog_left_r != '0) || (tail_cnt_r != 2'd0);
  assign emit      = busy && (!out_valid_r || out_tready);
  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign xor_new   = xor_r ^ b;
  assign k_inc     = bi_r + BI_W'(1);

  always_comb begin
    case (phase_r)
      ubcp_pkg::PH_ERASE:  frame_len = LW'(3);
      ubcp_pkg::PH_WADDR,
      ubcp_pkg::PH_CSTART,
      ubcp_pkg::PH_CEND:   frame_len = LW'(5);
      ubcp_pkg::PH_WDATA:  frame_len = LW'(wc_r) + LW'(1);
      default:             frame_len = LW'(2);
    endcase
  end

  assign done   = (LW'(k_inc) == frame_len);
  assign ram_we = in_acc && (in_tuser == ubcp_pkg::MODE_BYTE) &&
                  (phase_r == ubcp_pkg::PH_WDATA) && (LW'(bi_r) < LW'(wc_r));

  always_comb begin
    phase_nxt       = phase_r;
    bi_nxt          = bi_r;
    xor_nxt         = xor_r;
    accum_nxt       = accum_r;
    range_start_nxt = range_start_r;
    wc_nxt          = wc_r;
    e0_nxt          = e0_r;
    e1_nxt          = e1_r;
    prog_left_nxt   = prog_left_r;
    prog_idx_nxt    = prog_idx_r;
    tail_cnt_nxt    = tail_cnt_r;
    for (int i = 0; i < ubcp_pkg::TAIL_DEPTH; i++) begin
      tail_act_nxt[i] = tail_act_r[i];
    end
    out_valid_nxt = out_valid_r && !out_tready;
    out_act_nxt   = out_act_r;
    out_addr_nxt  = out_addr_r;
    out_end_nxt   = out_end_r;
    out_data_nxt  = out_data_r;
    out_first_nxt = out_first_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;

    // Sequencer: program requests first, then the fixed tail of answers.
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = '0;
      out_end_nxt   = '0;
      out_data_nxt  = '0;
      out_first_nxt = '0;
      out_count_nxt = '0;
      if (prog_left_r != '0) begin
        out_act_nxt   = ubcp_pkg::ACT_PROG;
        out_addr_nxt  = accum_r + 32'(prog_idx_r);
        out_data_nxt  = ram_rdata;
        out_last_nxt  = (prog_left_r == AW'(1)) && (tail_cnt_r == 2'd0);
        prog_left_nxt = prog_left_r - AW'(1);
        prog_idx_nxt  = prog_idx_r + AW'(1);
      end else begin
        out_act_nxt  = tail_act_r[0];
        out_last_nxt = (tail_cnt_r == 2'd1);
        case (tail_act_r[0])
          ubcp_pkg::ACT_ERASE: begin
            out_first_nxt = e1_r;
            out_count_nxt = e0_r;
          end
          ubcp_pkg::ACT_CHECK: begin
            out_addr_nxt = range_start_r;
            out_end_nxt  = accum_r;
          end
          default: ;
        endcase
        for (int i = 0; i < ubcp_pkg::TAIL_DEPTH - 1; i++) begin
          tail_act_nxt[i] = tail_act_r[i+1];
        end
        tail_act_nxt[ubcp_pkg::TAIL_DEPTH-1] = ubcp_pkg::ACT_ACK;
        tail_cnt_nxt = tail_cnt_r - 2'd1;
      end
    end

    // Input words are only taken while the sequencer is empty.
    if (in_acc) begin
      case (in_tuser)
        ubcp_pkg::MODE_START: begin
          phase_nxt       = ubcp_pkg::PH_HANDSHAKE;
          bi_nxt          = '0;
          xor_nxt         = '0;
          tail_act_nxt[0] = ubcp_pkg::ACT_ACK;
          tail_cnt_nxt    = 2'd1;
        end
        ubcp_pkg::MODE_TIMEOUT: begin
          bi_nxt  = '0;
          xor_nxt = '0;
          if (phase_r == ubcp_pkg::PH_HANDSHAKE) begin
            phase_nxt       = ubcp_pkg::PH_HALTED;
            tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
            tail_act_nxt[1] = ubcp_pkg::ACT_JUMP;
            tail_cnt_nxt    = 2'd2;
          end
        end
        ubcp_pkg::MODE_BYTE: begin
          if (phase_r != ubcp_pkg::PH_HALTED) begin
            if (bi_r == '0) begin
              e0_nxt = b;
            end
            if ((phase_r == ubcp_pkg::PH_WCOUNT) && (bi_r == '0)) begin
              wc_nxt = b;
            end
            if ((phase_r == ubcp_pkg::PH_ERASE) && (bi_r == BI_W'(1))) begin
              e1_nxt = b;
            end
            // Address bytes arrive least significant first.
            if (((phase_r == ubcp_pkg::PH_WADDR) || (phase_r == ubcp_pkg::PH_CSTART) ||
                 (phase_r == ubcp_pkg::PH_CEND)) && (bi_r < BI_W'(4))) begin
              case (bi_r[1:0])
                2'd0:    accum_nxt = {24'd0, b};
                2'd1:    accum_nxt[15:8] = b;
                2'd2:    accum_nxt[23:16] = b;
                default: accum_nxt[31:24] = b;
              endcase
            end

            if (!done) begin
              bi_nxt  = k_inc;
              xor_nxt = xor_new;
            end else begin
              bi_nxt  = '0;
              xor_nxt = '0;
              case (phase_r)
                ubcp_pkg::PH_HANDSHAKE: begin
                  if ((xor_new != 8'd0) || (e0_r != ubcp_pkg::CODE_ACK)) begin
                    phase_nxt       = ubcp_pkg::PH_HALTED;
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                    tail_act_nxt[1] = ubcp_pkg::ACT_JUMP;
                    tail_cnt_nxt    = 2'd2;
                  end else begin
                    phase_nxt = ubcp_pkg::PH_COMMAND;
                  end
                end
                ubcp_pkg::PH_COMMAND: begin
                  tail_act_nxt[0] = ubcp_pkg::ACT_ACK;
                  tail_cnt_nxt    = 2'd1;
                  if (xor_new != 8'd0) begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                  end else if (e0_r == ubcp_pkg::CMD_ERASE) begin
                    phase_nxt = ubcp_pkg::PH_ERASE;
                  end else if (e0_r == ubcp_pkg::CMD_WRITE) begin
                    phase_nxt = ubcp_pkg::PH_WADDR;
                  end else if (e0_r == ubcp_pkg::CMD_CHECK) begin
                    phase_nxt = ubcp_pkg::PH_CSTART;
                  end else if (e0_r == ubcp_pkg::CMD_JUMP) begin
                    phase_nxt       = ubcp_pkg::PH_HALTED;
                    tail_act_nxt[1] = ubcp_pkg::ACT_JUMP;
                    tail_cnt_nxt    = 2'd2;
                  end else begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                  end
                end
                ubcp_pkg::PH_ERASE: begin
                  phase_nxt = ubcp_pkg::PH_COMMAND;
                  if ((xor_new != 8'd0) || (e0_r == ubcp_pkg::GLOBAL_ERASE)) begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                    tail_cnt_nxt    = 2'd1;
                  end else begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_ERASE;
                    tail_act_nxt[1] = ubcp_pkg::ACT_ACK;
                    tail_cnt_nxt    = 2'd2;
                  end
                end
                ubcp_pkg::PH_WADDR: begin
                  tail_cnt_nxt = 2'd1;
                  if (xor_new != 8'd0) begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                    phase_nxt       = ubcp_pkg::PH_COMMAND;
                  end else begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_ACK;
                    phase_nxt       = ubcp_pkg::PH_WCOUNT;
                  end
                end
                ubcp_pkg::PH_WCOUNT: begin
                  // The second byte of the count frame is not checked.
                  if (LW'(wc_r) > LW'(MAX_WRITE_BYTES)) begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                    tail_cnt_nxt    = 2'd1;
                    phase_nxt       = ubcp_pkg::PH_COMMAND;
                  end else begin
                    phase_nxt = ubcp_pkg::PH_WDATA;
                  end
                end
                ubcp_pkg::PH_WDATA: begin
                  phase_nxt    = ubcp_pkg::PH_COMMAND;
                  tail_cnt_nxt = 2'd1;
                  if (xor_new != 8'd0) begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                  end else begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_ACK;
                    prog_left_nxt   = AW'(wc_r);
                    prog_idx_nxt    = '0;
                  end
                end
                ubcp_pkg::PH_CSTART: begin
                  tail_cnt_nxt = 2'd1;
                  if (xor_new != 8'd0) begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                    phase_nxt       = ubcp_pkg::PH_COMMAND;
                  end else begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_ACK;
                    range_start_nxt = accum_r;
                    phase_nxt       = ubcp_pkg::PH_CEND;
                  end
                end
                ubcp_pkg::PH_CEND: begin
                  if (xor_new != 8'd0) begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_NACK;
                    tail_cnt_nxt    = 2'd1;
                    phase_nxt       = ubcp_pkg::PH_COMMAND;
                  end else begin
                    tail_act_nxt[0] = ubcp_pkg::ACT_ACK;
                    tail_act_nxt[1] = ubcp_pkg::ACT_CHECK;
                    tail_act_nxt[2] = ubcp_pkg::ACT_JUMP;
                    tail_cnt_nxt    = 2'd3;
                    phase_nxt       = ubcp_pkg::PH_HALTED;
                  end
                end
                default: phase_nxt = ubcp_pkg::PH_HALTED;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The read address is taken from prog_idx_nxt, so the registered data for
  // prog_idx_r is always present when that byte is emitted.
  ubcp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bi_r[AW-1:0]),
    .wdata (b),
    .raddr (prog_idx_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ubcp_pkg::PH_HANDSHAKE;
      bi_r          <= '0;
      xor_r         <= '0;
      accum_r       <= '0;
      range_start_r <= '0;
      wc_r          <= '0;
      e0_r          <= '0;
      e1_r          <= '0;
      prog_left_r   <= '0;
      prog_idx_r    <= '0;
      tail_cnt_r    <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      bi_r          <= bi_nxt;
      xor_r         <= xor_nxt;
      accum_r       <= accum_nxt;
      range_start_r <= range_start_nxt;
      wc_r          <= wc_nxt;
      e0_r          <= e0_nxt;
      e1_r          <= e1_nxt;
      prog_left_r   <= prog_left_nxt;
      prog_idx_r    <= prog_idx_nxt;
      tail_cnt_r    <= tail_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ubcp_pkg::TAIL_DEPTH; i++) begin
      tail_act_r[i] <= tail_act_nxt[i];
    end
    out_act_r   <= out_act_nxt;
    out_addr_r  <= out_addr_nxt;
    out_end_r   <= out_end_nxt;
    out_data_r  <= out_data_nxt;
    out_first_r <= out_first_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_first_r, out_data_r, out_end_r, out_addr_r};
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

  `UBCP_ASSERT_NEXT(a_run_continues, clk, rst_n, out_tvalid && out_tready && !out_tlast,
                    out_tvalid, "result run broke off before its last word")
  `UBCP_ASSERT_NOW(a_no_input_mid_run, clk, rst_n, out_tvalid && !out_tlast,
                   !in_tready, "input accepted while results of a word are still pending")
  `UBCP_ASSERT_NOW(a_replay_in_command, clk, rst_n, prog_left_r != '0,
                   phase_r == ubcp_pkg::PH_COMMAND, "program replay outside command phase")

endmodule
